// ----- hw/rtl/vgfm_pkg.sv -----
// shared types and constants of the greedy face mesher
package vgfm_pkg;

  localparam int unsigned EDGE        = 16;
  localparam int unsigned EW          = 4;
  localparam int unsigned CHUNK_DEPTH = 4096;
  localparam int unsigned PLANE_DEPTH = 1536;
  localparam int unsigned CHUNK_AW    = 12;
  localparam int unsigned PLANE_AW    = 11;
  localparam int unsigned CFG_IW      = 3;

  localparam logic [1:0] FUNC_LOAD_CHUNK = 2'd0;
  localparam logic [1:0] FUNC_LOAD_NBR   = 2'd1;
  localparam logic [1:0] FUNC_MESH       = 2'd2;

  localparam logic [2:0] FACE_POS_Y = 3'd0;
  localparam logic [2:0] FACE_NEG_Y = 3'd1;
  localparam logic [2:0] FACE_POS_X = 3'd2;
  localparam logic [2:0] FACE_NEG_X = 3'd3;
  localparam logic [2:0] FACE_POS_Z = 3'd4;
  localparam logic [2:0] FACE_NEG_Z = 3'd5;

  localparam logic [CFG_IW-1:0] CFG_AIR     = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_LADDER  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_TRANS_0 = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_TRANS_1 = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_TRANS_2 = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_TRANS_3 = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_NBR     = 3'd6;

  typedef enum logic [3:0] {
    OP_NONE, OP_ACCEPT, OP_BA, OP_BB, OP_BC, OP_ROWRD, OP_ROWLD, OP_SCAN,
    OP_EXTV, OP_URD, OP_UCMP, OP_MARK, OP_EMIT, OP_FINISH
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BA, ST_BB, ST_BC, ST_ROWRD, ST_ROWLD, ST_SCAN, ST_EXTV,
    ST_URD, ST_UCMP, ST_MARK, ST_EMIT, ST_FINISH
  } state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic mesh;
    logic row_zero;
    logic cnt_last;
    logic hit;
    logic v_last;
    logic ext_ok;
    logic ue_end;
    logic u_match;
    logic ve_end;
    logic pending;
    logic out_busy;
  } dp_status_t;

endpackage

// ----- hw/rtl/vgfm_ctrl.sv -----
// sequencer of the greedy face mesher
module vgfm_ctrl import vgfm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   fire;

  assign in_ready_o = (state_q == ST_IDLE);
  assign fire       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (fire && status_i.mesh) begin
          state_d = status_i.row_zero ? ST_BA : ST_ROWRD;
        end
      end
      ST_BA: state_d = ST_BB;
      ST_BB: state_d = ST_BC;
      ST_BC: state_d = status_i.cnt_last ? ST_ROWRD : ST_BA;
      ST_ROWRD: state_d = ST_ROWLD;
      ST_ROWLD: state_d = ST_SCAN;
      ST_SCAN: begin
        if (status_i.hit) begin
          state_d = ST_EXTV;
        end else if (status_i.v_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_EXTV: begin
        if (!status_i.ext_ok) begin
          state_d = ST_URD;
        end
      end
      ST_URD: state_d = status_i.ue_end ? ST_MARK : ST_UCMP;
      ST_UCMP: state_d = status_i.u_match ? ST_URD : ST_MARK;
      ST_MARK: state_d = ST_EMIT;
      ST_EMIT: begin
        if (!(status_i.pending && status_i.out_busy)) begin
          state_d = status_i.ve_end ? ST_FINISH : ST_SCAN;
        end
      end
      ST_FINISH: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op = OP_NONE;
    case (state_q)
      ST_IDLE:   cmd_o.op = fire ? OP_ACCEPT : OP_NONE;
      ST_BA:     cmd_o.op = OP_BA;
      ST_BB:     cmd_o.op = OP_BB;
      ST_BC:     cmd_o.op = OP_BC;
      ST_ROWRD:  cmd_o.op = OP_ROWRD;
      ST_ROWLD:  cmd_o.op = OP_ROWLD;
      ST_SCAN:   cmd_o.op = OP_SCAN;
      ST_EXTV:   cmd_o.op = OP_EXTV;
      ST_URD:    cmd_o.op = OP_URD;
      ST_UCMP:   cmd_o.op = OP_UCMP;
      ST_MARK:   cmd_o.op = OP_MARK;
      ST_EMIT:   cmd_o.op = OP_EMIT;
      ST_FINISH: cmd_o.op = OP_FINISH;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// ----- hw/rtl/vgfm_dp.sv -----
// datapath of the greedy face mesher: stores, slice mask, visited map, output register
module vgfm_dp import vgfm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_status_t        status_o,
  input  logic [1:0]        func_i,
  input  logic [2:0]        face_i,
  input  logic [EW-1:0]     cell_x_i,
  input  logic [EW-1:0]     cell_y_i,
  input  logic [EW-1:0]     cell_z_i,
  input  logic [7:0]        cell_material_i,
  input  logic [EW-1:0]     slice_depth_i,
  input  logic [EW-1:0]     row_index_i,
  input  logic              cfg_valid_i,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [63:0]       cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        face_dir_o,
  output logic [EW-1:0]     quad_depth_o,
  output logic [EW-1:0]     u_start_o,
  output logic [EW:0]       u_end_o,
  output logic [EW-1:0]     v_start_o,
  output logic [EW:0]       v_end_o,
  output logic [7:0]        quad_material_o,
  output logic              quad_valid_o,
  output logic              last_o
);

  logic [7:0]   air_q, ladder_q;
  logic [255:0] trans_q;
  logic [5:0]   np_q;

  logic [2:0]    face_q;
  logic [EW-1:0] depth_q, row_q;

  logic [7:0]               cnt_q;
  logic [EDGE-1:0][8:0]     rowbuf_q;
  logic [EDGE-1:0][8:0]     cur_row_q;
  logic [7:0]               m_q;
  logic [EW-1:0]            v_q;
  logic [EW:0]              ve_q, ue_q;
  logic [8:0]               cell_q;
  logic [EDGE-1:0][EDGE-1:0] visited_q;

  logic          pend_vld_q;
  logic [EW-1:0] pend_v_q;
  logic [EW:0]   pend_ue_q, pend_ve_q;
  logic [7:0]    pend_mat_q;

  logic [7:0]          chunk_mem [CHUNK_DEPTH];
  logic [7:0]          plane_mem [PLANE_DEPTH];
  logic [EDGE-1:0][8:0] slice_mem [EDGE];
  logic [7:0]          chunk_rd_q, plane_rd_q;
  logic [EDGE-1:0][8:0] slice_rd_q;

  logic          out_valid_q, out_busy;
  logic [2:0]    o_face_q;
  logic [EW-1:0] o_depth_q, o_us_q, o_vs_q;
  logic [EW:0]   o_ue_q, o_ve_q;
  logic [7:0]    o_mat_q;
  logic          o_qv_q, o_last_q;

  logic          fok, accept;
  logic [EW-1:0] bu, bv;
  logic [EW-1:0] cx, cy, cz, nx, ny, nz;
  logic [CHUNK_AW-1:0] cell_addr, nbr_addr, chunk_ra, chunk_wa;
  logic [PLANE_AW-1:0] plane_ra, plane_wa;
  logic [EW-1:0]       lu, lw, slice_ra;
  logic          outc, has, t, nt, m_airl, nm_airl, expo, cvalid;
  logic [7:0]    nm;
  logic [7:0]    np_ext;
  logic [EDGE-1:0][8:0] row_next;
  logic [EDGE-1:0] colmask;
  logic          u_match, emit_go, fin_go;

  assign accept = (cmd_i.op == OP_ACCEPT);
  assign fok    = (face_q <= FACE_NEG_Z);
  assign bu     = cnt_q[7:4];
  assign bv     = cnt_q[3:0];
  assign np_ext = {2'b00, np_q};

  // slice coordinates to chunk coordinates
  always_comb begin
    if (face_q < FACE_POS_X) begin
      cx = bu; cy = depth_q; cz = bv;
    end else if (face_q < FACE_POS_Z) begin
      cx = depth_q; cy = bv; cz = bu;
    end else begin
      cx = bu; cy = bv; cz = depth_q;
    end
    nx = cx; ny = cy; nz = cz;
    case (face_q)
      FACE_POS_Y: ny = cy + 4'd1;
      FACE_NEG_Y: ny = cy - 4'd1;
      FACE_POS_X: nx = cx + 4'd1;
      FACE_NEG_X: nx = cx - 4'd1;
      FACE_POS_Z: nz = cz + 4'd1;
      default:    nz = cz - 4'd1;
    endcase
  end

  assign cell_addr = {cy, cz, cx};
  assign nbr_addr  = {ny, nz, nx};
  assign chunk_ra  = (cmd_i.op == OP_BB) ? nbr_addr : cell_addr;
  assign chunk_wa  = {cell_y_i, cell_z_i, cell_x_i};
  assign plane_ra  = fok ? {face_q, bu, bv} : '0;

  always_comb begin
    if (face_i < FACE_POS_X) begin
      lu = cell_x_i; lw = cell_z_i;
    end else if (face_i < FACE_POS_Z) begin
      lu = cell_z_i; lw = cell_y_i;
    end else begin
      lu = cell_x_i; lw = cell_y_i;
    end
  end
  assign plane_wa = {face_i, lu, lw};

  assign slice_ra = (cmd_i.op == OP_URD) ? ue_q[EW-1:0] : row_q;

  // exposure of the cell under build
  assign outc    = face_q[0] ? (depth_q == '0) : (depth_q == {EW{1'b1}});
  assign has     = !outc || np_ext[face_q];
  assign nm      = outc ? plane_rd_q : chunk_rd_q;
  assign t       = trans_q[m_q];
  assign nt      = trans_q[nm];
  assign m_airl  = (m_q == air_q) || (m_q == ladder_q);
  assign nm_airl = (nm == air_q) || (nm == ladder_q);

  always_comb begin
    if (!has) begin
      expo = !t || (face_q == FACE_POS_Y);
    end else if (nm_airl) begin
      expo = 1'b1;
    end else if (!t) begin
      expo = nt;
    end else begin
      expo = nt && (nm != m_q) && (m_q > nm);
    end
  end
  assign cvalid = fok && !m_airl && expo;

  always_comb begin
    row_next     = rowbuf_q;
    row_next[bv] = {cvalid, m_q};
  end

  always_comb begin
    for (int j = 0; j < EDGE; j++) begin
      colmask[j] = ({1'b0, EW'(j)} >= {1'b0, v_q}) && ({1'b0, EW'(j)} < ve_q);
    end
  end

  always_comb begin
    u_match = 1'b1;
    for (int j = 0; j < EDGE; j++) begin
      if (colmask[j] && ((slice_rd_q[j] != cell_q) || visited_q[ue_q[EW-1:0]][j])) begin
        u_match = 1'b0;
      end
    end
  end

  assign out_busy = out_valid_q && !out_ready_i;
  assign emit_go  = (cmd_i.op == OP_EMIT) && !(pend_vld_q && out_busy);
  assign fin_go   = (cmd_i.op == OP_FINISH) && !out_busy;

  assign status_o.mesh     = (func_i == FUNC_MESH);
  assign status_o.row_zero = (row_index_i == '0);
  assign status_o.cnt_last = (cnt_q == 8'hFF);
  assign status_o.hit      = fok && cur_row_q[v_q][8] && !visited_q[row_q][v_q];
  assign status_o.v_last   = (v_q == {EW{1'b1}});
  assign status_o.ext_ok   = !ve_q[EW] && !visited_q[row_q][ve_q[EW-1:0]]
                             && (cur_row_q[ve_q[EW-1:0]] == cell_q);
  assign status_o.ue_end   = ue_q[EW];
  assign status_o.u_match  = u_match;
  assign status_o.ve_end   = ve_q[EW];
  assign status_o.pending  = pend_vld_q;
  assign status_o.out_busy = out_busy;

  // memories
  always_ff @(posedge clk_i) begin
    if (accept && (func_i == FUNC_LOAD_CHUNK)) begin
      chunk_mem[chunk_wa] <= cell_material_i;
    end
    chunk_rd_q <= chunk_mem[chunk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (accept && (func_i == FUNC_LOAD_NBR) && (face_i <= FACE_NEG_Z)) begin
      plane_mem[plane_wa] <= cell_material_i;
    end
    plane_rd_q <= plane_mem[plane_ra];
  end

  always_ff @(posedge clk_i) begin
    if ((cmd_i.op == OP_BC) && (bv == {EW{1'b1}})) begin
      slice_mem[bu] <= row_next;
    end
    slice_rd_q <= slice_mem[slice_ra];
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      air_q    <= '0;
      ladder_q <= '0;
      trans_q  <= '0;
      np_q     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_AIR:     air_q           <= cfg_data_i[7:0];
        CFG_LADDER:  ladder_q        <= cfg_data_i[7:0];
        CFG_TRANS_0: trans_q[63:0]   <= cfg_data_i;
        CFG_TRANS_1: trans_q[127:64] <= cfg_data_i;
        CFG_TRANS_2: trans_q[191:128] <= cfg_data_i;
        CFG_TRANS_3: trans_q[255:192] <= cfg_data_i;
        CFG_NBR:     np_q            <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // item, build and scan registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ACCEPT: begin
        face_q  <= face_i;
        depth_q <= slice_depth_i;
        row_q   <= row_index_i;
        cnt_q   <= '0;
      end
      OP_BB: m_q <= chunk_rd_q;
      OP_BC: begin
        rowbuf_q <= row_next;
        cnt_q    <= cnt_q + 8'd1;
      end
      OP_ROWLD: begin
        cur_row_q <= slice_rd_q;
        v_q       <= '0;
      end
      OP_SCAN: begin
        if (status_o.hit) begin
          cell_q <= cur_row_q[v_q];
          ve_q   <= {1'b0, v_q} + 5'd1;
        end else begin
          v_q <= v_q + 4'd1;
        end
      end
      OP_EXTV: begin
        if (status_o.ext_ok) begin
          ve_q <= ve_q + 5'd1;
        end else begin
          ue_q <= {1'b0, row_q} + 5'd1;
        end
      end
      OP_UCMP: begin
        if (u_match) begin
          ue_q <= ue_q + 5'd1;
        end
      end
      OP_EMIT: begin
        if (emit_go) begin
          pend_v_q   <= v_q;
          pend_ue_q  <= ue_q;
          pend_ve_q  <= ve_q;
          pend_mat_q <= cell_q[7:0];
          v_q        <= ve_q[EW-1:0];
        end
      end
      default: ;
    endcase
  end

  // visited map and pending quad
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q  <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        pend_vld_q <= 1'b0;
        if ((func_i == FUNC_MESH) && (row_index_i == '0)) begin
          visited_q <= '0;
        end
      end
      if (cmd_i.op == OP_MARK) begin
        for (int uu = 0; uu < EDGE; uu++) begin
          if (({1'b0, EW'(uu)} >= {1'b0, row_q}) && ({1'b0, EW'(uu)} < ue_q)) begin
            visited_q[uu] <= visited_q[uu] | colmask;
          end
        end
      end
      if (emit_go) begin
        pend_vld_q <= 1'b1;
      end
      if (fin_go) begin
        pend_vld_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((emit_go && pend_vld_q) || fin_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((emit_go && pend_vld_q) || (fin_go && pend_vld_q)) begin
      o_face_q  <= face_q;
      o_depth_q <= depth_q;
      o_us_q    <= row_q;
      o_ue_q    <= pend_ue_q;
      o_vs_q    <= pend_v_q;
      o_ve_q    <= pend_ve_q;
      o_mat_q   <= pend_mat_q;
      o_qv_q    <= 1'b1;
      o_last_q  <= fin_go;
    end else if (fin_go) begin
      o_face_q  <= face_q;
      o_depth_q <= depth_q;
      o_us_q    <= '0;
      o_ue_q    <= '0;
      o_vs_q    <= '0;
      o_ve_q    <= '0;
      o_mat_q   <= '0;
      o_qv_q    <= 1'b0;
      o_last_q  <= 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign face_dir_o      = o_face_q;
  assign quad_depth_o    = o_depth_q;
  assign u_start_o       = o_us_q;
  assign u_end_o         = o_ue_q;
  assign v_start_o       = o_vs_q;
  assign v_end_o         = o_ve_q;
  assign quad_material_o = o_mat_q;
  assign quad_valid_o    = o_qv_q;
  assign last_o          = o_last_q;

endmodule

// ----- hw/rtl/voxel_greedy_face_mesher_unit.sv -----
// top level of the greedy voxel face mesher
// load items are taken without leaving idle; a mesh item holds the input until its last result is registered
// row 0 first builds the slice mask cell by cell over the chunk memory port (states BA, BB, BC)
// each row is then read (ROWRD, ROWLD) and scanned; a quad is grown along v, then along u, marked and emitted
// results leave through one output register, so a busy output stalls the scan
// reset clears control, configuration and the visited map; the stores are not cleared
module voxel_greedy_face_mesher_unit import vgfm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        func_i,
  input  logic [2:0]        face_i,
  input  logic [EW-1:0]     cell_x_i,
  input  logic [EW-1:0]     cell_y_i,
  input  logic [EW-1:0]     cell_z_i,
  input  logic [7:0]        cell_material_i,
  input  logic [EW-1:0]     slice_depth_i,
  input  logic [EW-1:0]     row_index_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [63:0]       cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        face_dir_o,
  output logic [EW-1:0]     quad_depth_o,
  output logic [EW-1:0]     u_start_o,
  output logic [EW:0]       u_end_o,
  output logic [EW-1:0]     v_start_o,
  output logic [EW:0]       v_end_o,
  output logic [7:0]        quad_material_o,
  output logic              quad_valid_o,
  output logic              last_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  vgfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  vgfm_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .func_i          (func_i),
    .face_i          (face_i),
    .cell_x_i        (cell_x_i),
    .cell_y_i        (cell_y_i),
    .cell_z_i        (cell_z_i),
    .cell_material_i (cell_material_i),
    .slice_depth_i   (slice_depth_i),
    .row_index_i     (row_index_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .face_dir_o      (face_dir_o),
    .quad_depth_o    (quad_depth_o),
    .u_start_o       (u_start_o),
    .u_end_o         (u_end_o),
    .v_start_o       (v_start_o),
    .v_end_o         (v_end_o),
    .quad_material_o (quad_material_o),
    .quad_valid_o    (quad_valid_o),
    .last_o          (last_o)
  );

  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !quad_valid_o |-> last_o)
    else $error("end marker without last");

  a_quad_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && quad_valid_o |->
      (u_end_o > {1'b0, u_start_o}) && (v_end_o > {1'b0, v_start_o}))
    else $error("empty quad transfer");

  a_mesh_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (func_i == FUNC_MESH) |=> !in_ready_o)
    else $error("input taken during mesh row");

  a_no_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result without mesh item");

endmodule
